// ----- sv/afr_pkg.sv -----
package afr_pkg;

  localparam int MAX_ORDER_DEF = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ACC_BITS      = 48;
  localparam int PROD_BITS     = 2 * ACC_BITS;
  localparam int QUOT_BITS     = 33;
  localparam int DIV_LAT       = QUOT_BITS + 2;

  localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};

  localparam logic [1:0] KIND_EVAL     = 2'd0;
  localparam logic [1:0] KIND_LOAD_NUM = 2'd1;
  localparam logic [1:0] KIND_LOAD_DEN = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DEN_ZERO = 2'd1;
  localparam logic [1:0] STAT_STORED   = 2'd2;

  typedef logic signed [ACC_BITS-1:0] afr_acc_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] omega;
    logic               last_in;
  } afr_in_t;

  typedef struct packed {
    logic signed [31:0] resp_re;
    logic signed [31:0] resp_im;
    logic [1:0]         status;
    logic               last_out;
  } afr_out_t;

  typedef struct packed {
    logic               valid;
    logic               load_num;
    logic               load_den;
    logic               last;
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               w_neg;
    logic [31:0]        w_mag;
  } afr_ctl_t;

  typedef struct packed {
    logic valid;
    logic is_eval;
    logic last;
    logic den_zero;
  } afr_tag_t;

endpackage

// ----- sv/afr_horner.sv -----
module afr_horner #(
  parameter int FRAC_BITS = afr_pkg::FRAC_BITS_DEF,
  parameter int K         = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               use_coef,
  input  afr_pkg::afr_ctl_t  ctl_in,
  input  afr_pkg::afr_acc_t  acc_in  [4],
  output afr_pkg::afr_ctl_t  ctl_out,
  output afr_pkg::afr_acc_t  acc_out [4]
);
  import afr_pkg::*;

  localparam int MW  = ACC_BITS - 1;
  localparam int HW  = MW - 32;
  localparam int PHW = HW + 32;
  localparam int SW  = MW + 33;
  localparam int DW  = ACC_BITS + 2;
  localparam logic signed [DW-1:0] DMAX = DW'(ACC_MAX);

  afr_ctl_t           ctl_a_r, ctl_b_r;
  logic [63:0]        plo_r [4];
  logic [PHW-1:0]     phi_r [4];
  logic               sgn_r [4];
  logic signed [31:0] num_coef_r, den_coef_r;
  afr_acc_t           acc_r [4];

  logic [MW-1:0]      mag     [4];
  logic               neg_src [4];
  logic [SW-1:0]      sum     [4];
  logic [SW-1:0]      trunc   [4];
  logic [MW-1:0]      lim     [4];
  afr_acc_t           val     [4];
  afr_acc_t           acc_nxt [4];
  logic signed [DW-1:0] dif   [4];
  logic signed [31:0] coef_c  [2];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      neg_src[l] = acc_in[l ^ 1][ACC_BITS-1];
      mag[l]     = neg_src[l] ? MW'(-acc_in[l ^ 1]) : acc_in[l ^ 1][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else if (en) begin
      ctl_a_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        plo_r[l] <= 64'(mag[l][31:0]) * 64'(ctl_in.w_mag);
        phi_r[l] <= PHW'(mag[l][MW-1:32]) * PHW'(ctl_in.w_mag);
        sgn_r[l] <= neg_src[l] ^ ctl_in.w_neg;
      end
    end
  end

  always_comb begin
    coef_c[0] = use_coef ? num_coef_r : '0;
    coef_c[1] = use_coef ? den_coef_r : '0;
    for (int l = 0; l < 4; l++) begin
      sum[l]   = SW'(plo_r[l]) + (SW'(phi_r[l]) << 32);
      trunc[l] = sum[l] >> FRAC_BITS;
      lim[l]   = (trunc[l] > SW'(ACC_MAX)) ? ACC_MAX[MW-1:0] : trunc[l][MW-1:0];
      val[l]   = sgn_r[l] ? -$signed({1'b0, lim[l]}) : $signed({1'b0, lim[l]});
      dif[l]   = DW'(coef_c[l / 2]) - DW'(val[l]);
      if (l % 2 == 1) begin
        acc_nxt[l] = val[l];
      end else if (dif[l] > DMAX) begin
        acc_nxt[l] = ACC_MAX;
      end else if (dif[l] < -DMAX) begin
        acc_nxt[l] = -ACC_MAX;
      end else begin
        acc_nxt[l] = dif[l][ACC_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_coef_r <= '0;
      den_coef_r <= '0;
    end else if (en && ctl_a_r.valid && int'(ctl_a_r.idx) == K) begin
      if (ctl_a_r.load_num) begin
        num_coef_r <= ctl_a_r.value;
      end
      if (ctl_a_r.load_den) begin
        den_coef_r <= ctl_a_r.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else if (en) begin
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        acc_r[l] <= acc_nxt[l];
      end
    end
  end

  assign ctl_out = ctl_b_r;
  assign acc_out = acc_r;

endmodule

// ----- sv/afr_div.sv -----
module afr_div #(
  parameter int FRAC_BITS = afr_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [afr_pkg::PROD_BITS-1:0]  p,
  input  logic [afr_pkg::PROD_BITS-1:0]         m,
  output logic [31:0]                           q
);
  import afr_pkg::*;

  localparam int DW = PROD_BITS + QUOT_BITS + FRAC_BITS;

  logic [DW-1:0]        r_r   [QUOT_BITS+1];
  logic [PROD_BITS-1:0] m_r   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] q_r   [QUOT_BITS+1];
  logic                 neg_r [QUOT_BITS+1];
  logic                 ovf_r [QUOT_BITS+1];
  logic [31:0]          q_out_r;

  logic [PROD_BITS-1:0] abs_p;
  logic [DW-1:0]        n0;
  logic [QUOT_BITS-1:0] qf;
  logic [QUOT_BITS-1:0] qneg;
  logic [31:0]          q_nxt;

  always_comb begin
    abs_p = p[PROD_BITS-1] ? PROD_BITS'(-p) : PROD_BITS'(p);
    n0    = DW'(abs_p) << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= n0;
      m_r[0]   <= m;
      q_r[0]   <= '0;
      neg_r[0] <= p[PROD_BITS-1];
      ovf_r[0] <= n0 >= (DW'(m) << QUOT_BITS);
    end
  end

  for (genvar i = 1; i <= QUOT_BITS; i++) begin : g_bit
    localparam int B = QUOT_BITS - i;
    logic [DW-1:0]        sh;
    logic                 ge;
    logic [QUOT_BITS-1:0] qb;

    always_comb begin
      sh    = DW'(m_r[i-1]) << B;
      ge    = r_r[i-1] >= sh;
      qb    = q_r[i-1];
      qb[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[i]   <= ge ? r_r[i-1] - sh : r_r[i-1];
        m_r[i]   <= m_r[i-1];
        q_r[i]   <= qb;
        neg_r[i] <= neg_r[i-1];
        ovf_r[i] <= ovf_r[i-1];
      end
    end
  end

  always_comb begin
    qf   = q_r[QUOT_BITS];
    qneg = -qf;
    if (neg_r[QUOT_BITS]) begin
      if (ovf_r[QUOT_BITS] || qf > QUOT_BITS'(33'h080000000)) begin
        q_nxt = 32'h80000000;
      end else begin
        q_nxt = qneg[31:0];
      end
    end else if (ovf_r[QUOT_BITS] || qf > QUOT_BITS'(33'h07FFFFFFF)) begin
      q_nxt = 32'h7FFFFFFF;
    end else begin
      q_nxt = qf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_out_r <= q_nxt;
    end
  end

  assign q = q_out_r;

endmodule

// ----- sv/analog_freq_response_top.sv -----
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall   afr_in_t  (kind, index, value, omega, last)
// out_     output     out_valid / out_stall afr_out_t (re, im, status, last)
// cfg_     input      cfg_we                cfg_wdata = filter order
//
// One item enters per cycle while the output is not stalled.
// Horner steps take two stages each, the quotient one bit per stage (33 stages).
// Reset clears the coefficient tables, the order and all valid bits.
// A stalled output freezes the whole pipeline; in_stall follows it.
module analog_freq_response_top #(
  parameter int MAX_ORDER = afr_pkg::MAX_ORDER_DEF,
  parameter int FRAC_BITS = afr_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  afr_pkg::afr_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output afr_pkg::afr_out_t out_item,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata
);
  import afr_pkg::*;

  localparam int NSTEP = MAX_ORDER + 1;
  localparam int MW    = ACC_BITS - 1;
  localparam int HW    = MW - 32;

  logic       en;
  logic [3:0] filter_order_r;
  afr_ctl_t   ctl_c [NSTEP+1];
  afr_acc_t   acc_c [NSTEP+1][4];

  logic [63:0]        pll_r [6];
  logic [HW+31:0]     plh_r [6];
  logic [HW+31:0]     phl_r [6];
  logic [2*HW-1:0]    phh_r [6];
  logic               psg_r [6];
  logic signed [PROD_BITS-1:0] sp_r [6];
  logic signed [PROD_BITS-1:0] p_r, q_r;
  logic [PROD_BITS-1:0]        m_r;
  afr_tag_t   tag_p1_r, tag_p2_r, tag_p3_r;
  afr_tag_t   tag_d_r [DIV_LAT];
  logic [31:0] re_q, im_q;
  logic        out_valid_r;
  afr_out_t    out_item_r, out_item_nxt;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_order_r <= '0;
    end else if (cfg_we) begin
      filter_order_r <= cfg_wdata;
    end
  end

  always_comb begin
    ctl_c[0].valid    = in_valid;
    ctl_c[0].load_num = in_item.kind == KIND_LOAD_NUM;
    ctl_c[0].load_den = in_item.kind == KIND_LOAD_DEN;
    ctl_c[0].last     = in_item.last_in;
    ctl_c[0].idx      = in_item.coef_index;
    ctl_c[0].value    = in_item.coef_value;
    ctl_c[0].w_neg    = in_item.omega[31];
    ctl_c[0].w_mag    = in_item.omega[31] ? 32'(-in_item.omega) : 32'(in_item.omega);
    for (int l = 0; l < 4; l++) begin
      acc_c[0][l] = '0;
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    afr_horner #(.FRAC_BITS(FRAC_BITS), .K(MAX_ORDER - j)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .use_coef ((MAX_ORDER - j) <= int'(filter_order_r)),
      .ctl_in   (ctl_c[j]),
      .acc_in   (acc_c[j]),
      .ctl_out  (ctl_c[j+1]),
      .acc_out  (acc_c[j+1])
    );
  end

  for (genvar g = 0; g < 6; g++) begin : g_prod
    localparam int A = (g == 0 || g == 3) ? 0 : (g == 1 || g == 2) ? 1 : (g == 4) ? 2 : 3;
    localparam int B = (g == 0 || g == 2 || g == 4) ? 2 : 3;
    logic [MW-1:0] ma, mb;

    always_comb begin
      ma = acc_c[NSTEP][A][ACC_BITS-1] ? MW'(-acc_c[NSTEP][A]) : acc_c[NSTEP][A][MW-1:0];
      mb = acc_c[NSTEP][B][ACC_BITS-1] ? MW'(-acc_c[NSTEP][B]) : acc_c[NSTEP][B][MW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pll_r[g] <= 64'(ma[31:0]) * 64'(mb[31:0]);
        plh_r[g] <= (HW+32)'(ma[31:0]) * (HW+32)'(mb[MW-1:32]);
        phl_r[g] <= (HW+32)'(ma[MW-1:32]) * (HW+32)'(mb[31:0]);
        phh_r[g] <= (2*HW)'(ma[MW-1:32]) * (2*HW)'(mb[MW-1:32]);
        psg_r[g] <= acc_c[NSTEP][A][ACC_BITS-1] ^ acc_c[NSTEP][B][ACC_BITS-1];
      end
    end

    logic [PROD_BITS-1:0] smag;
    always_comb begin
      smag = PROD_BITS'(pll_r[g]) + ((PROD_BITS'(plh_r[g]) + PROD_BITS'(phl_r[g])) << 32)
           + (PROD_BITS'(phh_r[g]) << 64);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sp_r[g] <= psg_r[g] ? -$signed(smag) : $signed(smag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sp_r[0] + sp_r[1];
      q_r <= sp_r[2] - sp_r[3];
      m_r <= PROD_BITS'(sp_r[4]) + PROD_BITS'(sp_r[5]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_p1_r <= '0;
      tag_p2_r <= '0;
      tag_p3_r <= '0;
      for (int i = 0; i < DIV_LAT; i++) begin
        tag_d_r[i] <= '0;
      end
    end else if (en) begin
      tag_p1_r.valid    <= ctl_c[NSTEP].valid;
      tag_p1_r.is_eval  <= !(ctl_c[NSTEP].load_num || ctl_c[NSTEP].load_den);
      tag_p1_r.last     <= ctl_c[NSTEP].last;
      tag_p1_r.den_zero <= 1'b0;
      tag_p2_r          <= tag_p1_r;
      tag_p3_r.valid    <= tag_p2_r.valid;
      tag_p3_r.is_eval  <= tag_p2_r.is_eval;
      tag_p3_r.last     <= tag_p2_r.last;
      tag_p3_r.den_zero <= (PROD_BITS'(sp_r[4]) + PROD_BITS'(sp_r[5])) == '0;
      tag_d_r[0]        <= tag_p3_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        tag_d_r[i] <= tag_d_r[i-1];
      end
    end
  end

  afr_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk (clk),
    .en  (en),
    .p   (p_r),
    .m   (m_r),
    .q   (re_q)
  );

  afr_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk (clk),
    .en  (en),
    .p   (q_r),
    .m   (m_r),
    .q   (im_q)
  );

  always_comb begin
    if (!tag_d_r[DIV_LAT-1].is_eval) begin
      out_item_nxt = '{resp_re: '0, resp_im: '0, status: STAT_STORED, last_out: 1'b0};
    end else if (tag_d_r[DIV_LAT-1].den_zero) begin
      out_item_nxt = '{resp_re: '0, resp_im: '0, status: STAT_DEN_ZERO,
                       last_out: tag_d_r[DIV_LAT-1].last};
    end else begin
      out_item_nxt = '{resp_re: re_q, resp_im: im_q, status: STAT_OK,
                       last_out: tag_d_r[DIV_LAT-1].last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_d_r[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == STAT_STORED |->
      out_item_r.resp_re == '0 && out_item_r.resp_im == '0 && !out_item_r.last_out)
    else $error("load item result not cleared");

  a_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == STAT_DEN_ZERO |->
      out_item_r.resp_re == '0 && out_item_r.resp_im == '0)
    else $error("zero denominator gave a nonzero response");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.status == STAT_OK || out_item_r.status == STAT_DEN_ZERO ||
                     out_item_r.status == STAT_STORED))
    else $error("undefined status code");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(tag_d_r[DIV_LAT-1]))
    else $error("pipeline moved under stall");

endmodule
